// ===== src/cuat_pkg.sv =====
// ----------------------------------------------------------------------------
// Card UID access table package
// Shared widths, action and status codes, controller states and the command
// and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package cuat_pkg;

  localparam int ACTION_W = 2;
  localparam int LEN_W    = 4;
  localparam int LOW_W    = 64;
  localparam int HIGH_W   = 16;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 4;
  localparam int COUNT_W  = 4;
  localparam int SEQ_W    = 32;
  localparam int BYTE_W   = 8;
  localparam int PORT_UID_BYTES = (LOW_W + HIGH_W) / BYTE_W;

  localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_LEN = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

  localparam logic [INDEX_W-1:0] NO_MATCH_INDEX = 4'hF;
  localparam logic [BYTE_W-1:0]  BYTE_MASK      = 8'hFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } cuat_cmd_t;

  typedef struct packed {
    logic needs_scan;
    logic scan_done;
    logic out_free;
  } cuat_stat_t;

endpackage

// ===== src/cuat_ctrl.sv =====
// ----------------------------------------------------------------------------
// Card UID access table controller
// Sequences one request at a time: accept, a table scan when one is needed, then
// commit of the result into the output register.
// ----------------------------------------------------------------------------
module cuat_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  cuat_pkg::cuat_stat_t stat,
  output cuat_pkg::cuat_cmd_t  cmd
);
  import cuat_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = stat.needs_scan ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = !rst;
        cmd.start = req_valid && !rst;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/cuat_dp.sv =====
// ----------------------------------------------------------------------------
// Card UID access table datapath
// Request register, entry memory with a sequential compare, entry and
// sequence counters, and the result register.
// ----------------------------------------------------------------------------
module cuat_dp #(
  parameter int MAX_ENTRIES   = 9,
  parameter int UID_MAX_BYTES = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cuat_pkg::ACTION_W-1:0]     action,
  input  logic [cuat_pkg::LEN_W-1:0]        uid_length,
  input  logic [cuat_pkg::LOW_W-1:0]        uid_low_bytes,
  input  logic [cuat_pkg::HIGH_W-1:0]       uid_high_bytes,
  input  logic                              enable_flag,
  input  cuat_pkg::cuat_cmd_t               cmd,
  output cuat_pkg::cuat_stat_t              stat,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output logic [cuat_pkg::STATUS_W-1:0]     status,
  output logic                              found,
  output logic                              authorized,
  output logic [cuat_pkg::INDEX_W-1:0]      match_index,
  output logic                              table_empty,
  output logic [cuat_pkg::COUNT_W-1:0]      entry_count,
  output logic [cuat_pkg::SEQ_W-1:0]        change_sequence
);
  import cuat_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int UID_W = UID_MAX_BYTES * BYTE_W;

  logic [PORT_UID_BYTES*BYTE_W-1:0] port_uid;
  logic [PORT_UID_BYTES*BYTE_W-1:0] clip_uid;
  logic                             len_ok_in;

  logic [ACTION_W-1:0] req_action;
  logic [LEN_W-1:0]    req_len;
  logic [UID_W-1:0]    req_uid;
  logic                req_flag;
  logic                req_len_ok;

  logic [UID_W-1:0] mem_uid [MAX_ENTRIES];
  logic [LEN_W-1:0] mem_len [MAX_ENTRIES];
  logic             mem_en  [MAX_ENTRIES];
  logic [UID_W-1:0] rd_uid;
  logic [LEN_W-1:0] rd_len;
  logic             rd_en;
  logic             rd_req;

  logic [CNT_W-1:0] scan_idx;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             match;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             hit_en;

  logic [CNT_W-1:0] held_count;
  logic [CNT_W-1:0] held_count_next;
  logic [SEQ_W-1:0] seq_count;
  logic [SEQ_W-1:0] seq_count_next;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;

  logic [STATUS_W-1:0] res_status;
  logic                res_found;
  logic                res_auth;
  logic [INDEX_W-1:0]  res_index;

  assign port_uid  = {uid_high_bytes, uid_low_bytes};
  assign len_ok_in = (uid_length != '0) && (uid_length <= LEN_W'(UID_MAX_BYTES));

  always_comb begin
    clip_uid = '0;
    for (int b = 0; b < PORT_UID_BYTES; b++) begin
      if (LEN_W'(b) < uid_length) begin
        clip_uid[b*BYTE_W +: BYTE_W] = port_uid[b*BYTE_W +: BYTE_W] & BYTE_MASK;
      end
    end
  end

  assign stat.needs_scan = ((action == ACT_CHECK) || (action == ACT_ADD)) && len_ok_in;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_action <= action;
      req_len    <= uid_length;
      req_uid    <= clip_uid[UID_W-1:0];
      req_flag   <= enable_flag;
      req_len_ok <= len_ok_in;
    end
  end

  assign rd_req = cmd.scan && (scan_idx < held_count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_uid[wr_addr] <= req_uid;
      mem_len[wr_addr] <= req_len;
      mem_en[wr_addr]  <= req_flag;
    end
    if (rd_req) begin
      rd_uid <= mem_uid[scan_idx[IDX_W-1:0]];
      rd_len <= mem_len[scan_idx[IDX_W-1:0]];
      rd_en  <= mem_en[scan_idx[IDX_W-1:0]];
    end
  end

  assign match          = cmp_vld && (rd_len == req_len) && (rd_uid == req_uid);
  assign stat.scan_done = match || (!cmp_vld && (scan_idx >= held_count));

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      cmp_vld  <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.start) begin
      scan_idx <= '0;
      cmp_vld  <= 1'b0;
      hit      <= 1'b0;
    end else if (cmd.scan) begin
      cmp_vld <= rd_req;
      if (rd_req) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (match) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx <= scan_idx[IDX_W-1:0];
      if (match) begin
        hit_idx <= cmp_idx;
        hit_en  <= rd_en;
      end
    end
  end

  always_comb begin
    held_count_next = held_count;
    seq_count_next  = seq_count;
    wr_en           = 1'b0;
    wr_addr         = hit_idx;
    res_status      = STAT_OK;
    res_found       = 1'b0;
    res_auth        = 1'b0;
    res_index       = NO_MATCH_INDEX;
    if (cmd.commit) begin
      priority if ((req_action == ACT_CHECK) || (req_action == ACT_ADD)) begin
        priority if (!req_len_ok) begin
          res_status = STAT_BAD_LEN;
        end else if (req_action == ACT_CHECK) begin
          if (hit) begin
            res_found = 1'b1;
            res_auth  = hit_en;
            res_index = INDEX_W'(hit_idx);
          end
        end else if (hit) begin
          wr_en          = 1'b1;
          seq_count_next = seq_count + SEQ_W'(1);
        end else if (held_count >= CNT_W'(MAX_ENTRIES)) begin
          res_status = STAT_FULL;
        end else begin
          wr_en           = 1'b1;
          wr_addr         = held_count[IDX_W-1:0];
          held_count_next = held_count + CNT_W'(1);
          seq_count_next  = seq_count + SEQ_W'(1);
        end
      end else if (req_action == ACT_CLEAR) begin
        held_count_next = '0;
        seq_count_next  = seq_count + SEQ_W'(1);
      end else begin
        res_status = STAT_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      seq_count  <= '0;
      rsp_valid  <= 1'b0;
    end else if (cmd.commit) begin
      held_count <= held_count_next;
      seq_count  <= seq_count_next;
      rsp_valid  <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status          <= res_status;
      found           <= res_found;
      authorized      <= res_auth;
      match_index     <= res_index;
      table_empty     <= (held_count_next == '0);
      entry_count     <= COUNT_W'(held_count_next);
      change_sequence <= seq_count_next;
    end
  end

  assign stat.out_free = !rsp_valid || rsp_ready;

`ifndef ASSERT_OFF
  a_commit_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || rsp_ready))
    else $error("Result committed over an unread beat.");

  a_seq_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(seq_count))
    else $error("Sequence count changed outside a commit.");

  a_count_matches_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count == COUNT_W'(held_count)))
    else $error("Reported entry count differs from the table.");

  a_full_reported: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && (req_action == ACT_ADD) && req_len_ok && !hit &&
     (held_count == CNT_W'(MAX_ENTRIES))) |=> (status == STAT_FULL))
    else $error("Add into a full table not reported as full.");
`endif

endmodule

// ===== src/card_uid_access_table.sv =====
// ----------------------------------------------------------------------------
// Card UID access table
// Small list of card UIDs searched by exact match of length and bytes, with
// check, add-or-update and clear actions and a change sequence count.
//
//   Channel   Handshake               Payload
//   request   req_valid / req_ready   action, uid_length, uid_low_bytes,
//                                     uid_high_bytes, enable_flag
//   response  rsp_valid / rsp_ready   status, found, authorized, match_index,
//                                     table_empty, entry_count, change_sequence
//
// A check or add of valid length scans the entries held, stopping at the first
// match; one entry is compared per cycle.
// A clear, an unused action or a bad length skips the scan and goes to commit.
// One request is in progress at a time; the next is taken once the result is
// registered, and its own commit waits while that earlier beat is unread.
// Reset empties the table and zeroes the sequence count at once.
// ----------------------------------------------------------------------------
module card_uid_access_table #(
  parameter int MAX_ENTRIES   = 9,
  parameter int UID_MAX_BYTES = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [cuat_pkg::ACTION_W-1:0] action,
  input  logic [cuat_pkg::LEN_W-1:0]    uid_length,
  input  logic [cuat_pkg::LOW_W-1:0]    uid_low_bytes,
  input  logic [cuat_pkg::HIGH_W-1:0]   uid_high_bytes,
  input  logic                          enable_flag,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [cuat_pkg::STATUS_W-1:0] status,
  output logic                          found,
  output logic                          authorized,
  output logic [cuat_pkg::INDEX_W-1:0]  match_index,
  output logic                          table_empty,
  output logic [cuat_pkg::COUNT_W-1:0]  entry_count,
  output logic [cuat_pkg::SEQ_W-1:0]    change_sequence
);
  import cuat_pkg::*;

  cuat_cmd_t  cmd;
  cuat_stat_t stat;

  cuat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cuat_dp #(
    .MAX_ENTRIES   (MAX_ENTRIES),
    .UID_MAX_BYTES (UID_MAX_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .action          (action),
    .uid_length      (uid_length),
    .uid_low_bytes   (uid_low_bytes),
    .uid_high_bytes  (uid_high_bytes),
    .enable_flag     (enable_flag),
    .cmd             (cmd),
    .stat            (stat),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .status          (status),
    .found           (found),
    .authorized      (authorized),
    .match_index     (match_index),
    .table_empty     (table_empty),
    .entry_count     (entry_count),
    .change_sequence (change_sequence)
  );

endmodule

// ===== sim/card_uid_access_table_check.sv =====
// ----------------------------------------------------------------------------
// Card UID access table checker
// Watches the request and response channels of the access table. It keeps
// its own copy of the table and sequence count, works out the result of
// every accepted request beat and compares each accepted response beat,
// field by field, with the oldest result still awaited.
// ----------------------------------------------------------------------------
module card_uid_access_table_check #(
  parameter int MAX_ENTRIES   = 9,
  parameter int UID_MAX_BYTES = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  input  logic                          req_ready,
  input  logic [cuat_pkg::ACTION_W-1:0] action,
  input  logic [cuat_pkg::LEN_W-1:0]    uid_length,
  input  logic [cuat_pkg::LOW_W-1:0]    uid_low_bytes,
  input  logic [cuat_pkg::HIGH_W-1:0]   uid_high_bytes,
  input  logic                          enable_flag,
  input  logic                          rsp_valid,
  input  logic                          rsp_ready,
  input  logic [cuat_pkg::STATUS_W-1:0] status,
  input  logic                          found,
  input  logic                          authorized,
  input  logic [cuat_pkg::INDEX_W-1:0]  match_index,
  input  logic                          table_empty,
  input  logic [cuat_pkg::COUNT_W-1:0]  entry_count,
  input  logic [cuat_pkg::SEQ_W-1:0]    change_sequence,
  output int                            failures,
  output int                            outstanding
);
  import cuat_pkg::*;

  localparam int UID_W = LOW_W + HIGH_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic                authorized;
    logic [INDEX_W-1:0]  match_index;
    logic                table_empty;
    logic [COUNT_W-1:0]  entry_count;
    logic [SEQ_W-1:0]    change_sequence;
  } lookup_result_t;

  logic [UID_W-1:0] uid_mem [MAX_ENTRIES];
  logic [LEN_W-1:0] len_mem [MAX_ENTRIES];
  logic             en_mem  [MAX_ENTRIES];
  int               held;
  logic [SEQ_W-1:0] seq;
  int               fault_total;
  lookup_result_t   awaited_results [$];

  function automatic lookup_result_t apply_request(
    input logic [ACTION_W-1:0] act,
    input logic [LEN_W-1:0]    len,
    input logic [LOW_W-1:0]    lo,
    input logic [HIGH_W-1:0]   hi,
    input logic                flag
  );
    logic [UID_W-1:0] uid;
    logic [UID_W-1:0] mask;
    int               hit;
    lookup_result_t   res;
    res = '0;
    res.status = STAT_OK;
    res.match_index = NO_MATCH_INDEX;
    if (act == ACT_CHECK || act == ACT_ADD) begin
      if (len == 0 || len > UID_MAX_BYTES) begin
        res.status = STAT_BAD_LEN;
      end else begin
        mask = '0;
        for (int b = 0; b < UID_MAX_BYTES; b++) begin
          if (b < len) mask[b*BYTE_W +: BYTE_W] = BYTE_MASK;
        end
        uid = {hi, lo} & mask;
        hit = MAX_ENTRIES;
        for (int i = 0; i < held; i++) begin
          if (hit == MAX_ENTRIES && len_mem[i] == len && uid_mem[i] == uid) hit = i;
        end
        if (act == ACT_CHECK) begin
          if (hit < MAX_ENTRIES) begin
            res.found = 1'b1;
            res.authorized = en_mem[hit];
            res.match_index = hit[INDEX_W-1:0];
          end
        end else if (hit < MAX_ENTRIES) begin
          en_mem[hit] = flag;
          seq = seq + 1'b1;
        end else if (held >= MAX_ENTRIES) begin
          res.status = STAT_FULL;
        end else begin
          uid_mem[held] = uid;
          len_mem[held] = len;
          en_mem[held] = flag;
          held = held + 1;
          seq = seq + 1'b1;
        end
      end
    end else if (act == ACT_CLEAR) begin
      held = 0;
      seq = seq + 1'b1;
    end
    res.table_empty = (held == 0);
    res.entry_count = held[COUNT_W-1:0];
    res.change_sequence = seq;
    return res;
  endfunction

  task automatic note_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fault_total++;
    end
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      held = 0;
      seq = '0;
      fault_total = 0;
      awaited_results.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_results.size() == 0) begin
          $error("response beat with no result awaited");
          fault_total++;
        end else begin
          want = awaited_results.pop_front();
          note_field("status", want.status, status);
          note_field("found", want.found, found);
          note_field("authorized", want.authorized, authorized);
          note_field("match_index", want.match_index, match_index);
          note_field("table_empty", want.table_empty, table_empty);
          note_field("entry_count", want.entry_count, entry_count);
          note_field("change_sequence", want.change_sequence, change_sequence);
        end
      end
      if (req_valid && req_ready) begin
        awaited_results.push_back(apply_request(action, uid_length, uid_low_bytes,
                                                uid_high_bytes, enable_flag));
      end
    end
    failures <= fault_total;
    outstanding <= awaited_results.size();
  end

endmodule

// ===== sim/card_uid_access_table_test.sv =====
// ----------------------------------------------------------------------------
// Card UID access table testbench
// Drives check, add-or-update and clear requests into the access table,
// first a directed set covering bad lengths, a full table, updates, clears
// and the unused action, then random requests drawn mostly from a pool of
// known UIDs with noise beyond their length. Both channels idle at random.
// A separate checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
module card_uid_access_table_test;
  import cuat_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int KEYS         = 12;
  localparam int UID_BYTES    = 10;
  localparam int RANDOM_ITEMS = 1450;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 30;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [ACTION_W-1:0] action = ACT_CHECK;
  logic [LEN_W-1:0]    uid_length = '0;
  logic [LOW_W-1:0]    uid_low_bytes = '0;
  logic [HIGH_W-1:0]   uid_high_bytes = '0;
  logic                enable_flag = 1'b0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic                authorized;
  logic [INDEX_W-1:0]  match_index;
  logic                table_empty;
  logic [COUNT_W-1:0]  entry_count;
  logic [SEQ_W-1:0]    change_sequence;

  int   failures;
  int   outstanding;
  int   cycle_count = 0;
  int   stall_left = 0;
  logic steady = 1'b0;

  logic [LOW_W+HIGH_W-1:0] key_uid [KEYS];
  logic [LEN_W-1:0]        key_len [KEYS];

  card_uid_access_table u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .action(action), .uid_length(uid_length), .uid_low_bytes(uid_low_bytes),
    .uid_high_bytes(uid_high_bytes), .enable_flag(enable_flag),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .found(found), .authorized(authorized),
    .match_index(match_index), .table_empty(table_empty),
    .entry_count(entry_count), .change_sequence(change_sequence)
  );

  card_uid_access_table_check u_check (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .action(action), .uid_length(uid_length), .uid_low_bytes(uid_low_bytes),
    .uid_high_bytes(uid_high_bytes), .enable_flag(enable_flag),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .status(status), .found(found), .authorized(authorized),
    .match_index(match_index), .table_empty(table_empty),
    .entry_count(entry_count), .change_sequence(change_sequence),
    .failures(failures), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    int pick;
    pick = $urandom_range(0, 99);
    if (rst) begin
      rsp_ready <= 1'b0;
      stall_left <= 0;
    end else if (steady) begin
      rsp_ready <= 1'b1;
    end else if (stall_left != 0) begin
      rsp_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (pick < 70) begin
      rsp_ready <= 1'b1;
    end else if (pick < 95) begin
      rsp_ready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      rsp_ready <= 1'b0;
      stall_left <= $urandom_range(10, 40);
    end
  end

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (steady || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Called at a clock edge; returns at the edge where the beat is taken.
  task automatic send_beat(
    input logic [ACTION_W-1:0] act,
    input logic [LEN_W-1:0]    len,
    input logic [LOW_W-1:0]    lo,
    input logic [HIGH_W-1:0]   hi,
    input logic                flag
  );
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    action <= act;
    uid_length <= len;
    uid_low_bytes <= lo;
    uid_high_bytes <= hi;
    enable_flag <= flag;
    do @(posedge clk); while (!req_ready);
  endtask

  // Sends a pool UID at the given length, with random bytes beyond it.
  task automatic send_key(
    input logic [ACTION_W-1:0] act,
    input int                  k,
    input logic [LEN_W-1:0]    len,
    input logic                flag
  );
    logic [LOW_W+HIGH_W-1:0] uid;
    uid = key_uid[k];
    for (int b = 0; b < UID_BYTES; b++) begin
      if (b >= len) uid[b*8 +: 8] = 8'($urandom);
    end
    send_beat(act, len, uid[LOW_W-1:0], uid[LOW_W+HIGH_W-1:LOW_W], flag);
  endtask

  initial begin
    int pick;
    int k;
    logic [LEN_W-1:0] len;
    for (int i = 0; i < KEYS; i++) begin
      key_len[i] = LEN_W'(i % UID_BYTES + 1);
      // Odd keys share the bytes of the key before them but not its length.
      if (i % 2 == 1) key_uid[i] = key_uid[i-1];
      else key_uid[i] = {16'($urandom), $urandom, $urandom};
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_key(ACT_CHECK, 0, key_len[0], 1'b0);
    send_key(ACT_CHECK, 0, 4'd0, 1'b0);
    send_key(ACT_ADD, 2, 4'd11, 1'b1);
    send_beat(ACT_ADD, 4'd15, '1, '1, 1'b1);
    for (int i = 0; i < 8; i++) send_key(ACT_ADD, i, key_len[i], i[0]);
    send_key(ACT_ADD, 9, key_len[9], 1'b1);
    send_key(ACT_ADD, 8, key_len[8], 1'b1);
    send_key(ACT_ADD, 3, key_len[3], 1'b0);
    send_key(ACT_CHECK, 3, key_len[3], 1'b0);
    send_key(ACT_CHECK, 9, key_len[9], 1'b0);
    send_key(ACT_CHECK, 8, key_len[8], 1'b0);
    send_beat(ACT_UNUSED, '1, '1, '1, 1'b1);
    send_beat(ACT_CLEAR, '1, '1, '1, 1'b1);
    send_beat(ACT_CLEAR, '0, '0, '0, 1'b0);
    send_key(ACT_CHECK, 0, key_len[0], 1'b0);
    send_beat(ACT_ADD, 4'd10, '1, '1, 1'b1);
    send_beat(ACT_CHECK, 4'd10, '1, '1, 1'b0);
    send_beat(ACT_ADD, 4'd1, '0, '0, 1'b0);
    send_beat(ACT_CHECK, 4'd1, {{56{1'b1}}, 8'h00}, '1, 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) steady <= ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, KEYS - 1);
      len = key_len[k];
      if (pick < 10) len = LEN_W'($urandom_range(1, UID_BYTES));
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_beat(ACT_CLEAR, LEN_W'($urandom), {$urandom, $urandom}, 16'($urandom),
                  1'($urandom));
      end else if (pick < 7) begin
        send_beat(ACT_UNUSED, LEN_W'($urandom), {$urandom, $urandom}, 16'($urandom),
                  1'($urandom));
      end else if (pick < 15) begin
        send_beat(pick[0] ? ACT_ADD : ACT_CHECK, LEN_W'($urandom),
                  {$urandom, $urandom}, 16'($urandom), 1'($urandom));
      end else if (pick < 55) begin
        send_key(ACT_CHECK, k, len, 1'($urandom));
      end else begin
        send_key(ACT_ADD, k, len, 1'($urandom));
      end
    end
    req_valid <= 1'b0;
    steady <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
